>>> design/stc_pkg.sv
// Shared types, constants and modular helpers for the spanning tree counter.
package stc_pkg;

   localparam int MAX_NODES_DEF = 32;
   localparam int NODE_W        = 6;
   localparam int VAL_W         = 30;

   // Prime modulus and the Fermat inverse exponent
   localparam logic [VAL_W-1:0] MODP  = 30'd998244353;
   localparam logic [VAL_W-1:0] EXP_C = 30'd998244351;
   localparam logic [4:0]       EXP_LAST = 5'd29;

   typedef struct packed {
      logic [NODE_W-1:0] node_u;
      logic [NODE_W-1:0] node_v;
      logic              has_edge;
      logic              last_item;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] tree_count;
      logic             edge_dropped;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_START,
      ST_PIV_RD,
      ST_PIV_CK,
      ST_SWP_RD1,
      ST_SWP_RD2,
      ST_SWP_WR1,
      ST_SWP_WR2,
      ST_INV_RD,
      ST_INV_CK,
      ST_POW_R,
      ST_POW_RSV,
      ST_POW_B,
      ST_POW_BSV,
      ST_DET_SV,
      ST_ROW_RD,
      ST_ROW_CK,
      ST_FAC_SV,
      ST_ELM_RDI,
      ST_ELM_CKI,
      ST_ELM_RDJ,
      ST_ELM_WR,
      ST_NEXT_I,
      ST_MUL_WAIT,
      ST_OUT
   } state_type;

   function automatic logic [VAL_W-1:0] mod_inc(input logic [VAL_W-1:0] x);
      logic [VAL_W-1:0] s;
      s = x + VAL_W'(1);
      return (s == MODP) ? '0 : s;
   endfunction

   function automatic logic [VAL_W-1:0] mod_dec(input logic [VAL_W-1:0] x);
      return (x == '0) ? (MODP - VAL_W'(1)) : (x - VAL_W'(1));
   endfunction

   function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] x,
                                                input logic [VAL_W-1:0] y);
      return (x >= y) ? (x - y) : (x + (MODP - y));
   endfunction

   function automatic logic [VAL_W-1:0] mod_neg(input logic [VAL_W-1:0] x);
      return (x == '0) ? '0 : (MODP - x);
   endfunction

endpackage

>>> design/stc_mulmod.sv
// Bit-serial modular multiplier, one bit of the second operand per cycle.
module stc_mulmod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [stc_pkg::VAL_W-1:0] a,
   input  logic [stc_pkg::VAL_W-1:0] b,
   output logic                      done,
   output logic [stc_pkg::VAL_W-1:0] product
);
   import stc_pkg::*;

   localparam int CNT_W = $clog2(VAL_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] a_ff, a_in;
   logic [VAL_W-1:0] b_ff, b_in;
   logic [VAL_W:0]   dbl, sum;
   logic [VAL_W-1:0] dbl_r, step_val;

   // acc = 2*acc + bit*a, each term reduced with one compare-subtract
   always_comb begin
      dbl      = {acc_ff, 1'b0};
      dbl_r    = (dbl >= {1'b0, MODP}) ? VAL_W'(dbl - {1'b0, MODP}) : VAL_W'(dbl);
      sum      = {1'b0, dbl_r} + (b_ff[cnt_ff] ? {1'b0, a_ff} : '0);
      step_val = (sum >= {1'b0, MODP}) ? VAL_W'(sum - {1'b0, MODP}) : VAL_W'(sum);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VAL_W - 1);
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         acc_in = step_val;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> design/spanning_tree_count_mod_prime_core.sv
// Top level: spanning tree count modulo 998244353 over a Laplacian held in RAM.
// Usage:
//   req channel (req_valid/req_stall/req_data) carries edge items. An edge
//   item makes four read-modify-writes of the Laplacian RAM, each a read
//   state then a write state. Invalid edges and self-loops skip the RAM.
//   The item with last_item set starts the determinant of the leading
//   (n-1)x(n-1) minor by Gaussian elimination. Every modular product runs on a
//   bit-serial multiplier, and each pivot inverse takes about 60 products;
//   the elimination loop over the RAM sets the rate.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) gives one result per graph
//   from an output register; a stalled result holds there and the next one
//   waits behind it.
//   csr channel (csr_valid/csr_ready/csr_data) writes node_count; always ready.
//   After reset, and after each result, the RAM is swept to zero, one entry
//   per cycle over all 2**AW entries (1024 at the default); req_stall is held
//   high during the sweep, the edge updates and the computation.
module spanning_tree_count_mod_prime_core #(
   parameter int MAX_NODES = stc_pkg::MAX_NODES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  stc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output stc_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [stc_pkg::NODE_W-1:0] csr_data
);
   import stc_pkg::*;

   localparam int IW    = $clog2(MAX_NODES);
   localparam int NW    = $clog2(MAX_NODES + 1);
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 2 ** AW;
   localparam int CW    = (NW > NODE_W) ? NW + 1 : NODE_W + 1;

   // Laplacian RAM
   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;
   logic [AW-1:0]    raddr, waddr;
   logic             we;
   logic [VAL_W-1:0] wdata;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [NODE_W-1:0] ncfg_ff;
   logic [NW-1:0]     n_eff;
   logic [IW-1:0]     m_w;
   logic [IW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in, piv_ff, piv_in;
   logic [IW-1:0]     ea_ff, ea_in, eb_ff, eb_in;
   logic [1:0]        eidx_ff, eidx_in;
   logic              last_ff, last_in;
   logic              drop_ff, drop_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [VAL_W-1:0]  det_ff, det_in, tmp_ff, tmp_in, inv_ff, inv_in;
   logic [VAL_W-1:0]  r_ff, r_in, base_ff, base_in, f_ff, f_in;
   logic [4:0]        e_ff, e_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              edge_bad;

   // multiplier hookup
   logic             mul_start, mul_done;
   logic [VAL_W-1:0] mul_a, mul_b, mul_res;

   stc_mulmod u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_res)
   );

   // Effective node count, clamped to 1..MAX_NODES
   always_comb begin
      if (ncfg_ff == '0)
         n_eff = NW'(1);
      else if (CW'(ncfg_ff) > CW'(MAX_NODES))
         n_eff = NW'(MAX_NODES);
      else
         n_eff = NW'(ncfg_ff);
      m_w = IW'(n_eff - NW'(1));
   end

   assign edge_bad = (req_data.node_u == '0) || (req_data.node_v == '0) ||
                     (CW'(req_data.node_u) > CW'(n_eff)) ||
                     (CW'(req_data.node_v) > CW'(n_eff));

   // Control sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      piv_in       = piv_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      eidx_in      = eidx_ff;
      last_in      = last_ff;
      drop_in      = drop_ff;
      clr_in       = clr_ff;
      det_in       = det_ff;
      tmp_in       = tmp_ff;
      inv_in       = inv_ff;
      r_in         = r_ff;
      base_in      = base_ff;
      f_in         = f_ff;
      e_in         = e_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      raddr        = '0;
      waddr        = '0;
      we           = 1'b0;
      wdata        = '0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               last_in = req_data.last_item;
               ea_in   = IW'(req_data.node_u - NODE_W'(1));
               eb_in   = IW'(req_data.node_v - NODE_W'(1));
               eidx_in = '0;
               if (req_data.has_edge && edge_bad)
                  drop_in = 1'b1;
               if (req_data.has_edge && !edge_bad &&
                   (req_data.node_u != req_data.node_v))
                  state_in = ST_EDGE_RD;
               else if (req_data.last_item)
                  state_in = ST_START;
            end
         end
         ST_EDGE_RD: begin
            case (eidx_ff)
               2'd0:    raddr = {ea_ff, ea_ff};
               2'd1:    raddr = {eb_ff, eb_ff};
               2'd2:    raddr = {ea_ff, eb_ff};
               default: raddr = {eb_ff, ea_ff};
            endcase
            state_in = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            we = 1'b1;
            case (eidx_ff)
               2'd0:    waddr = {ea_ff, ea_ff};
               2'd1:    waddr = {eb_ff, eb_ff};
               2'd2:    waddr = {ea_ff, eb_ff};
               default: waddr = {eb_ff, ea_ff};
            endcase
            wdata   = eidx_ff[1] ? mod_dec(rdata_ff) : mod_inc(rdata_ff);
            eidx_in = eidx_ff + 2'd1;
            if (eidx_ff == 2'd3)
               state_in = last_ff ? ST_START : ST_IDLE;
            else
               state_in = ST_EDGE_RD;
         end
         ST_START: begin
            det_in = VAL_W'(1);
            i_in   = '0;
            piv_in = '0;
            if (n_eff == NW'(1))
               state_in = ST_OUT;
            else
               state_in = ST_PIV_RD;
         end
         // pivot search down column i
         ST_PIV_RD: begin
            raddr = {piv_ff, i_ff};
            if (piv_ff == m_w) begin
               det_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PIV_CK;
            end
         end
         ST_PIV_CK: begin
            if (rdata_ff == '0) begin
               piv_in   = piv_ff + IW'(1);
               state_in = ST_PIV_RD;
            end else if (piv_ff == i_ff) begin
               state_in = ST_INV_RD;
            end else begin
               k_in     = '0;
               det_in   = mod_neg(det_ff);
               state_in = ST_SWP_RD1;
            end
         end
         // row swap, one column at a time through two reads and two writes
         ST_SWP_RD1: begin
            raddr    = {i_ff, k_ff};
            state_in = ST_SWP_RD2;
         end
         ST_SWP_RD2: begin
            tmp_in   = rdata_ff;
            raddr    = {piv_ff, k_ff};
            state_in = ST_SWP_WR1;
         end
         ST_SWP_WR1: begin
            we       = 1'b1;
            waddr    = {i_ff, k_ff};
            wdata    = rdata_ff;
            state_in = ST_SWP_WR2;
         end
         ST_SWP_WR2: begin
            we    = 1'b1;
            waddr = {piv_ff, k_ff};
            wdata = tmp_ff;
            if (k_ff == m_w - IW'(1)) begin
               state_in = ST_INV_RD;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = ST_SWP_RD1;
            end
         end
         // Fermat inverse of the pivot, square and multiply
         ST_INV_RD: begin
            raddr    = {i_ff, i_ff};
            state_in = ST_INV_CK;
         end
         ST_INV_CK: begin
            tmp_in   = rdata_ff;
            base_in  = rdata_ff;
            r_in     = VAL_W'(1);
            e_in     = '0;
            state_in = ST_POW_R;
         end
         ST_POW_R: begin
            if (EXP_C[e_ff]) begin
               mul_start = 1'b1;
               mul_a     = r_ff;
               mul_b     = base_ff;
               ret_in    = ST_POW_RSV;
               state_in  = ST_MUL_WAIT;
            end else begin
               state_in = ST_POW_B;
            end
         end
         ST_POW_RSV: begin
            r_in     = mul_res;
            state_in = ST_POW_B;
         end
         ST_POW_B: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
            if (e_ff == EXP_LAST) begin
               inv_in = r_ff;
               mul_a  = det_ff;
               mul_b  = tmp_ff;
               ret_in = ST_DET_SV;
            end else begin
               mul_a  = base_ff;
               mul_b  = base_ff;
               ret_in = ST_POW_BSV;
            end
         end
         ST_POW_BSV: begin
            base_in  = mul_res;
            e_in     = e_ff + 5'd1;
            state_in = ST_POW_R;
         end
         ST_DET_SV: begin
            det_in   = mul_res;
            j_in     = i_ff + IW'(1);
            state_in = ST_ROW_RD;
         end
         // eliminate column i from the rows below
         ST_ROW_RD: begin
            raddr = {j_ff, i_ff};
            if (j_ff == m_w)
               state_in = ST_NEXT_I;
            else
               state_in = ST_ROW_CK;
         end
         ST_ROW_CK: begin
            if (rdata_ff == '0) begin
               j_in     = j_ff + IW'(1);
               state_in = ST_ROW_RD;
            end else begin
               mul_start = 1'b1;
               mul_a     = rdata_ff;
               mul_b     = inv_ff;
               ret_in    = ST_FAC_SV;
               state_in  = ST_MUL_WAIT;
            end
         end
         ST_FAC_SV: begin
            f_in     = mul_res;
            k_in     = i_ff;
            state_in = ST_ELM_RDI;
         end
         ST_ELM_RDI: begin
            raddr    = {i_ff, k_ff};
            state_in = ST_ELM_CKI;
         end
         ST_ELM_CKI: begin
            mul_start = 1'b1;
            mul_a     = f_ff;
            mul_b     = rdata_ff;
            ret_in    = ST_ELM_RDJ;
            state_in  = ST_MUL_WAIT;
         end
         ST_ELM_RDJ: begin
            raddr    = {j_ff, k_ff};
            state_in = ST_ELM_WR;
         end
         ST_ELM_WR: begin
            we    = 1'b1;
            waddr = {j_ff, k_ff};
            wdata = mod_sub(rdata_ff, mul_res);
            if (k_ff == m_w - IW'(1)) begin
               j_in     = j_ff + IW'(1);
               state_in = ST_ROW_RD;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = ST_ELM_RDI;
            end
         end
         ST_NEXT_I: begin
            if (i_ff == m_w - IW'(1)) begin
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff + IW'(1);
               piv_in   = i_ff + IW'(1);
               state_in = ST_PIV_RD;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done)
               state_in = ret_ff;
         end
         // hand the result to the output register, then sweep the RAM
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.tree_count   = det_ff;
               rsp_in.edge_dropped = drop_ff;
               drop_in            = 1'b0;
               det_in             = VAL_W'(1);
               clr_in             = '0;
               state_in           = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // Control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         drop_ff      <= 1'b0;
         det_ff       <= VAL_W'(1);
         rsp_valid_ff <= 1'b0;
         ncfg_ff      <= NODE_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         drop_ff      <= drop_in;
         det_ff       <= det_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid)
            ncfg_ff <= csr_data;
      end
      ret_ff  <= ret_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      piv_ff  <= piv_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      eidx_ff <= eidx_in;
      last_ff <= last_in;
      tmp_ff  <= tmp_in;
      inv_ff  <= inv_in;
      r_ff    <= r_in;
      base_ff <= base_in;
      f_ff    <= f_in;
      e_ff    <= e_in;
      rsp_ff  <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL_WAIT)
      else $error("multiplier finished outside a wait");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result appeared without completion");

   a_count_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.tree_count < MODP)
      else $error("tree count not reduced");

endmodule
